// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/ssnd_pkg.sv
// ----------------------------------------------------------------------------
// ssnd_pkg
// Constants, glyph patterns and helper functions for the number display.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssnd_pkg;

  // Number of display positions.
  localparam int DIGITS = 5;

  // Input value width and BCD working width.
  localparam int VALUE_W = 32;
  localparam int BCD_W   = 4 * DIGITS;

  // Position counter width, at least one bit.
  localparam int CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  // Field widths of one result.
  localparam int POS_W = 3;
  localparam int SEG_W = 8;

  // Decimal point sits on the units place in hundredths mode.
  localparam bit HAS_POINT = (DIGITS >= 3);
  localparam int POINT_POS = HAS_POINT ? DIGITS - 3 : 0;

  // Divide by 100 as multiply by reciprocal: floor(x * MAGIC / 2^37).
  localparam logic [VALUE_W-1:0] DIV100_MAGIC = 32'h51EB_851F;
  localparam int                 DIV100_SHIFT = 37;
  localparam int                 QUO_W        = 26;

  // Double-dabble conversion spread over register stages.
  localparam int DABBLE_STAGES = 4;
  localparam int DABBLE_STEPS  = VALUE_W / DABBLE_STAGES;

  // Prefix selector codes.
  localparam logic [1:0] PREFIX_DIGIT = 2'd0;
  localparam logic [1:0] PREFIX_H     = 2'd1;
  localparam logic [1:0] PREFIX_P     = 2'd2;

  // Glyph patterns; bit 7 is the decimal point.
  localparam logic [SEG_W-1:0] GLYPH_H   = 8'hDB;
  localparam logic [SEG_W-1:0] GLYPH_P   = 8'h9F;
  localparam logic [SEG_W-1:0] GLYPH_OFF = 8'h00;
  localparam logic [SEG_W-1:0] POINT_BIT = 8'h80;

  // Power of ten, evaluated at elaboration.
  function automatic logic [63:0] pow10(input int e);
    logic [63:0] p;
    p = 64'd1;
    for (int k = 0; k < e; k++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  // Values at or above this limit drop two decimals in hundredths mode.
  localparam logic [63:0] LIMIT = pow10(DIGITS);

  // Segment pattern of one decimal digit.
  function automatic logic [SEG_W-1:0] seg_of_digit(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'h7E;
      4'd1:    s = 8'h48;
      4'd2:    s = 8'h3D;
      4'd3:    s = 8'h6D;
      4'd4:    s = 8'h4B;
      4'd5:    s = 8'h67;
      4'd6:    s = 8'h77;
      4'd7:    s = 8'h4C;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = GLYPH_OFF;
    endcase
    return s;
  endfunction

  // One double-dabble step: correct each BCD digit, then shift in one bit.
  // Carries out of the top digit are dropped, which keeps the value
  // modulo 10^DIGITS.
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic             bit_in);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], bit_in};
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/seven_segment_number_display.sv
// ----------------------------------------------------------------------------
// seven_segment_number_display
// Converts one unsigned value into segment patterns for a multi-digit
// display, most significant position first, with prefix glyphs and an
// optional decimal point for values given in hundredths.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   input   | in        | valid_i / stall_o  | value_i, mode_i, prefix_i
//   output  | out       | valid_o / stall_i  | digit_position_o, segments_o, last_o
//
// One input transfer yields five output transfers, one per cycle while the
// output does not stall; the output serializer sets the sustained item rate.
// The first result of an item passes through the input register, which holds
// the divide-by-100 product, then four double-dabble stages, the serializer
// and the output register.
// Reset clears every valid bit and the position counter; no clearing pass.
// A stall on the output holds the result and backs up through the stages,
// which buffer up to six items without loss or repetition.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module seven_segment_number_display (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // Input channel
  input  wire                             valid_i,
  output logic                            stall_o,
  input  wire  [ssnd_pkg::VALUE_W-1:0]    value_i,
  input  wire                             mode_i,
  input  wire  [1:0]                      prefix_i,
  // Output channel
  output logic                            valid_o,
  input  wire                             stall_i,
  output logic [ssnd_pkg::POS_W-1:0]      digit_position_o,
  output logic [ssnd_pkg::SEG_W-1:0]      segments_o,
  output logic                            last_o
);

  localparam int NST = ssnd_pkg::DABBLE_STAGES;

  // Side information carried beside the number.
  typedef struct packed {
    logic       mode;
    logic [1:0] prefix;
    logic       point;
  } side_t;

  // --------------------------------------------------------------------------
  // Stage 1: register the item and divide by 100 through the multiplier.
  // --------------------------------------------------------------------------
  logic                               s1_vld_q;
  logic [ssnd_pkg::VALUE_W-1:0]       s1_value_q;
  logic [ssnd_pkg::QUO_W-1:0]         s1_quo_q;
  logic                               s1_big_q;
  logic                               s1_mode_q;
  logic [1:0]                         s1_prefix_q;
  logic                               s1_en;
  logic [2*ssnd_pkg::VALUE_W-1:0]     prod;
  logic                               big;

  logic [NST-1:0] en;

  assign s1_en   = !s1_vld_q || en[0];
  assign stall_o = !s1_en;
  assign prod    = {{ssnd_pkg::VALUE_W{1'b0}}, value_i} *
                   {{ssnd_pkg::VALUE_W{1'b0}}, ssnd_pkg::DIV100_MAGIC};
  assign big     = mode_i && ({{(64 - ssnd_pkg::VALUE_W){1'b0}}, value_i} >= ssnd_pkg::LIMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_en) begin
      s1_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_value_q  <= value_i;
      s1_quo_q    <= prod[ssnd_pkg::DIV100_SHIFT +: ssnd_pkg::QUO_W];
      s1_big_q    <= big;
      s1_mode_q   <= mode_i;
      s1_prefix_q <= prefix_i;
    end
  end

  // --------------------------------------------------------------------------
  // Double-dabble stages: each shifts in a fixed slice of the binary value.
  // --------------------------------------------------------------------------
  logic                          d_vld_q  [NST];
  logic [ssnd_pkg::VALUE_W-1:0]  d_bin_q  [NST];
  logic [ssnd_pkg::BCD_W-1:0]    d_bcd_q  [NST];
  side_t                         d_side_q [NST];

  logic [ssnd_pkg::VALUE_W-1:0]  bin_in   [NST];
  logic [ssnd_pkg::BCD_W-1:0]    bcd_in   [NST];
  side_t                         side_in  [NST];
  logic                          vld_in   [NST];
  logic [ssnd_pkg::VALUE_W-1:0]  bin_d    [NST];
  logic [ssnd_pkg::BCD_W-1:0]    bcd_d    [NST];

  logic ser_free;

  // Stage inputs: the first stage picks the divided or the plain value.
  always_comb begin
    bin_in[0]         = s1_big_q ?
                        {{(ssnd_pkg::VALUE_W - ssnd_pkg::QUO_W){1'b0}}, s1_quo_q} :
                        s1_value_q;
    bcd_in[0]         = '0;
    side_in[0].mode   = s1_mode_q;
    side_in[0].prefix = s1_prefix_q;
    side_in[0].point  = ssnd_pkg::HAS_POINT && s1_mode_q && !s1_big_q;
    vld_in[0]         = s1_vld_q;
    for (int s = 1; s < NST; s++) begin
      bin_in[s]  = d_bin_q[s-1];
      bcd_in[s]  = d_bcd_q[s-1];
      side_in[s] = d_side_q[s-1];
      vld_in[s]  = d_vld_q[s-1];
    end
  end

  // Conversion steps of each stage.
  always_comb begin
    logic [ssnd_pkg::VALUE_W-1:0] tb;
    logic [ssnd_pkg::BCD_W-1:0]   tc;
    for (int s = 0; s < NST; s++) begin
      tb = bin_in[s];
      tc = bcd_in[s];
      for (int k = 0; k < ssnd_pkg::DABBLE_STEPS; k++) begin
        tc = ssnd_pkg::dabble_step(tc, tb[ssnd_pkg::VALUE_W-1]);
        tb = {tb[ssnd_pkg::VALUE_W-2:0], 1'b0};
      end
      bin_d[s] = tb;
      bcd_d[s] = tc;
    end
  end

  // A stage advances when it is empty or its successor takes its item.
  always_comb begin
    en[NST-1] = !d_vld_q[NST-1] || ser_free;
    for (int s = NST - 2; s >= 0; s--) begin
      en[s] = !d_vld_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NST; s++) begin
        d_vld_q[s] <= 1'b0;
      end
    end else begin
      for (int s = 0; s < NST; s++) begin
        if (en[s]) begin
          d_vld_q[s] <= vld_in[s];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NST; s++) begin
      if (en[s]) begin
        d_bin_q[s]  <= bin_d[s];
        d_bcd_q[s]  <= bcd_d[s];
        d_side_q[s] <= side_in[s];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Serializer: holds one converted item and hands out one digit per cycle while the output is not stalled.
  // --------------------------------------------------------------------------
  logic                          ser_vld_q;
  logic [ssnd_pkg::BCD_W-1:0]    ser_bcd_q;
  side_t                         ser_side_q;
  logic [ssnd_pkg::CNT_W-1:0]    cnt_q;
  logic                          cnt_last;
  logic                          ser_load;
  logic                          out_free;
  logic                          emit;
  logic [ssnd_pkg::CNT_W-1:0]    dig_idx;
  logic [3:0]                    digit;
  logic [ssnd_pkg::SEG_W-1:0]    seg;

  logic                          out_vld_q;
  logic [ssnd_pkg::POS_W-1:0]    out_pos_q;
  logic [ssnd_pkg::SEG_W-1:0]    out_seg_q;
  logic                          out_last_q;

  assign out_free = !out_vld_q || !stall_i;
  assign emit     = ser_vld_q && out_free;
  assign cnt_last = (cnt_q == ssnd_pkg::CNT_W'(ssnd_pkg::DIGITS - 1));
  assign ser_free = !ser_vld_q || (emit && cnt_last);
  assign ser_load = d_vld_q[NST-1] && ser_free;
  assign dig_idx  = ssnd_pkg::CNT_W'(ssnd_pkg::DIGITS - 1) - cnt_q;

  // Segment pattern of the current position.
  always_comb begin
    digit = 4'd0;
    for (int d = 0; d < ssnd_pkg::DIGITS; d++) begin
      if (ssnd_pkg::CNT_W'(d) == dig_idx) begin
        digit = ser_bcd_q[4*d +: 4];
      end
    end
    seg = ssnd_pkg::seg_of_digit(digit);
    if (!ser_side_q.mode && cnt_q == '0 && ser_side_q.prefix != ssnd_pkg::PREFIX_DIGIT) begin
      case (ser_side_q.prefix)
        ssnd_pkg::PREFIX_H: seg = ssnd_pkg::GLYPH_H;
        ssnd_pkg::PREFIX_P: seg = ssnd_pkg::GLYPH_P;
        default:            seg = ssnd_pkg::GLYPH_OFF;
      endcase
    end
    if (ser_side_q.point && cnt_q == ssnd_pkg::CNT_W'(ssnd_pkg::POINT_POS)) begin
      seg = seg | ssnd_pkg::POINT_BIT;
    end
  end

  // Serializer control and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_vld_q <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (ser_load) begin
        ser_vld_q <= 1'b1;
        cnt_q     <= '0;
      end else if (emit) begin
        if (cnt_last) begin
          ser_vld_q <= 1'b0;
        end
        cnt_q <= cnt_q + 1'b1;
      end
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (!stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      ser_bcd_q  <= d_bcd_q[NST-1];
      ser_side_q <= d_side_q[NST-1];
    end
    if (emit) begin
      out_pos_q  <= ssnd_pkg::POS_W'(cnt_q);
      out_seg_q  <= seg;
      out_last_q <= cnt_last;
    end
  end

  assign valid_o          = out_vld_q;
  assign digit_position_o = out_pos_q;
  assign segments_o       = out_seg_q;
  assign last_o           = out_last_q;

endmodule

`default_nettype wire

// File: hw/rtl/ssnd_checker.sv
// ----------------------------------------------------------------------------
// ssnd_checker
// Port-level checks of the number display result sequence.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ssnd_checker (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          valid_o,
  input wire                          stall_i,
  input wire [ssnd_pkg::POS_W-1:0]    digit_position_o,
  input wire [ssnd_pkg::SEG_W-1:0]    segments_o,
  input wire                          last_o
);

  localparam logic [ssnd_pkg::POS_W-1:0] LAST_POS = ssnd_pkg::POS_W'(ssnd_pkg::DIGITS - 1);

  // Output transfer.
  logic out_xfer;
  assign out_xfer = valid_o && !stall_i;

  // A stalled result holds.
  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, valid_o && stall_i,
    valid_o && $stable(segments_o) && $stable(digit_position_o), "stalled result changed")

  // The last flag marks exactly the final position.
  `ASSERT_IMPLY(a_last_pos, clk_i, rst_ni, valid_o,
    last_o == (digit_position_o == LAST_POS), "last flag off the final position")

  // Within a run, the next position follows directly.
  `ASSERT_NEXT(a_pos_step, clk_i, rst_ni, out_xfer && !last_o,
    valid_o && digit_position_o == $past(digit_position_o) + 3'd1, "position did not advance")

  // After a run ends, a new run that follows directly starts at the leftmost position.
  `ASSERT_NEXT(a_run_start, clk_i, rst_ni, out_xfer && last_o,
    !valid_o || digit_position_o == 3'd0, "run did not restart at position zero")

endmodule

bind seven_segment_number_display ssnd_checker u_ssnd_checker (.*);

`default_nettype wire

// File: dv/tb_seven_segment_number_display.sv
// ----------------------------------------------------------------------------
// tb_seven_segment_number_display
// Self-checking bench for the five-digit number display decoder. A table of
// directed items and then random items are sent into the block. Each item
// is checked against typed-in patterns or a local model of the digit, glyph
// and decimal-point rules, one result per display position. Both sides idle
// and stall at random, and one long output hold-off fills the block's buffers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_seven_segment_number_display;

  // Mode and prefix codes that the package does not name.
  localparam logic       MODE_PLAIN      = 1'b0;
  localparam logic       MODE_HUNDREDTHS = 1'b1;
  localparam logic [1:0] PREFIX_BLANK    = 2'd3;

  localparam int N_DIRECTED        = 23;
  localparam int LONG_HOLD_CYCLES  = 80;
  localparam int DRAIN_CYCLES      = 20;
  localparam int CYCLE_LIMIT       = 200000;

  // Segment patterns of the decimal digits zero to nine.
  localparam logic [ssnd_pkg::SEG_W-1:0] DIGIT_GLYPH [10] = '{
    8'h7E, 8'h48, 8'h3D, 8'h6D, 8'h4B, 8'h67, 8'h77, 8'h4C, 8'h7F, 8'h6F
  };

  typedef struct packed {
    logic [ssnd_pkg::POS_W-1:0] pos;
    logic [ssnd_pkg::SEG_W-1:0] seg;
    logic                       last;
  } digit_result_t;

  // One directed item; segs holds position 0 in its top byte.
  typedef struct {
    logic [ssnd_pkg::VALUE_W-1:0]     value;
    logic                             mode;
    logic [1:0]                       prefix;
    bit                               typed;
    logic [8*ssnd_pkg::DIGITS-1:0]    segs;
  } directed_row_t;

  logic                          clk = 1'b0;
  logic                          rst_ni;
  logic                          valid_i;
  logic                          stall_o;
  logic [ssnd_pkg::VALUE_W-1:0]  value_i;
  logic                          mode_i;
  logic [1:0]                    prefix_i;
  logic                          valid_o;
  logic                          stall_i;
  logic [ssnd_pkg::POS_W-1:0]    digit_position_o;
  logic [ssnd_pkg::SEG_W-1:0]    segments_o;
  logic                          last_o;

  digit_result_t digit_q[$];
  directed_row_t directed_rows [N_DIRECTED];

  int  errors          = 0;
  int  items_sent      = 0;
  int  digits_checked  = 0;
  int  cycle_count     = 0;
  bit  sender_idle     = 1'b1;
  bit  receiver_idle   = 1'b1;
  bit  hold_request    = 1'b0;

  seven_segment_number_display DUT (
    .clk_i            (clk),
    .rst_ni           (rst_ni),
    .valid_i          (valid_i),
    .stall_o          (stall_o),
    .value_i          (value_i),
    .mode_i           (mode_i),
    .prefix_i         (prefix_i),
    .valid_o          (valid_o),
    .stall_i          (stall_i),
    .digit_position_o (digit_position_o),
    .segments_o       (segments_o),
    .last_o           (last_o)
  );

  // Free-running clock, 10 ns period.
  always #5 clk = ~clk;

  // Run limit in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Works out the five digit results of one item and queues them.
  task automatic queue_display_digits(input logic [ssnd_pkg::VALUE_W-1:0] value,
                                      input logic mode, input logic [1:0] prefix);
    logic [63:0]                num;
    logic [63:0]                scale;
    logic [3:0]                 digit;
    logic [ssnd_pkg::SEG_W-1:0] seg;
    bit                         point;
    num   = {32'd0, value};
    point = 1'b0;
    scale = 64'd1;
    for (int k = 0; k < ssnd_pkg::DIGITS - 1; k++) begin
      scale = scale * 64'd10;
    end
    // Hundredths mode drops two decimals once the value no longer fits.
    if (mode == MODE_HUNDREDTHS) begin
      point = (ssnd_pkg::DIGITS >= 3);
      if (num >= scale * 64'd10) begin
        num   = num / 64'd100;
        point = 1'b0;
      end
    end
    for (int i = 0; i < ssnd_pkg::DIGITS; i++) begin
      digit = 4'((num / scale) % 64'd10);
      seg   = DIGIT_GLYPH[digit];
      if (mode == MODE_PLAIN && i == 0 && prefix != ssnd_pkg::PREFIX_DIGIT) begin
        case (prefix)
          ssnd_pkg::PREFIX_H: seg = ssnd_pkg::GLYPH_H;
          ssnd_pkg::PREFIX_P: seg = ssnd_pkg::GLYPH_P;
          default:            seg = ssnd_pkg::GLYPH_OFF;
        endcase
      end
      if (point && i == ssnd_pkg::DIGITS - 3) begin
        seg = seg | ssnd_pkg::POINT_BIT;
      end
      digit_q.push_back('{pos: ssnd_pkg::POS_W'(i), seg: seg,
                          last: (i == ssnd_pkg::DIGITS - 1)});
      scale = scale / 64'd10;
    end
  endtask

  // Drives one item and waits for its transfer. Valid stays high afterwards.
  task automatic send_item(input logic [ssnd_pkg::VALUE_W-1:0] value, input logic mode,
                           input logic [1:0] prefix, input bit typed,
                           input logic [8*ssnd_pkg::DIGITS-1:0] segs);
    int gap;
    gap = (sender_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      @(negedge clk);
      valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    valid_i  <= 1'b1;
    value_i  <= value;
    mode_i   <= mode;
    prefix_i <= prefix;
    @(posedge clk);
    while (stall_o) @(posedge clk);
    items_sent++;
    if (typed) begin
      for (int i = 0; i < ssnd_pkg::DIGITS; i++) begin
        digit_q.push_back('{pos: ssnd_pkg::POS_W'(i),
                            seg: segs[8*(ssnd_pkg::DIGITS-1-i) +: 8],
                            last: (i == ssnd_pkg::DIGITS - 1)});
      end
    end else begin
      queue_display_digits(value, mode, prefix);
    end
  endtask

  // Random item, weighted toward the digit and overflow boundaries.
  task automatic send_random_item();
    logic [ssnd_pkg::VALUE_W-1:0] value;
    case ($urandom_range(0, 3))
      0:       value = $urandom;
      1:       value = $urandom_range(0, 99999);
      2:       value = 32'd99900 + $urandom_range(0, 200);
      default: value = $urandom_range(0, 9999999);
    endcase
    send_item(value, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), 1'b0, '0);
  endtask

  // Output side: random stall bursts, quiet stretches and one long hold-off.
  initial begin : receiver
    int n;
    stall_i = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        stall_i <= 1'b1;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else if (receiver_idle && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 10);
        stall_i <= 1'b1;
        repeat (n - 1) @(negedge clk);
      end else begin
        n = $urandom_range(1, 12);
        stall_i <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // Compares each output transfer with the oldest expected digit.
  always @(posedge clk) begin
    digit_result_t exp_digit;
    if (rst_ni && valid_o && !stall_i) begin
      if (digit_q.size() == 0) begin
        $error("Unexpected digit result: position %0d segments %h last %b",
               digit_position_o, segments_o, last_o);
        errors++;
      end else begin
        exp_digit = digit_q.pop_front();
        digits_checked++;
        if (digit_position_o !== exp_digit.pos) begin
          $error("digit_position: expected %0d, actual %0d", exp_digit.pos,
                 digit_position_o);
          errors++;
        end
        if (segments_o !== exp_digit.seg) begin
          $error("segments: expected %h, actual %h", exp_digit.seg, segments_o);
          errors++;
        end
        if (last_o !== exp_digit.last) begin
          $error("last: expected %b, actual %b", exp_digit.last, last_o);
          errors++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin : stimulus
    rst_ni   = 1'b0;
    valid_i  = 1'b0;
    value_i  = '0;
    mode_i   = 1'b0;
    prefix_i = 2'd0;

    // Expected patterns are typed in only where they are obvious.
    directed_rows = '{
      '{32'd0,        MODE_PLAIN,      ssnd_pkg::PREFIX_DIGIT, 1'b1, 40'h7E7E7E7E7E},
      '{32'd0,        MODE_PLAIN,      ssnd_pkg::PREFIX_H,     1'b1, 40'hDB7E7E7E7E},
      '{32'd0,        MODE_PLAIN,      ssnd_pkg::PREFIX_P,     1'b1, 40'h9F7E7E7E7E},
      '{32'd0,        MODE_PLAIN,      PREFIX_BLANK,           1'b1, 40'h007E7E7E7E},
      '{32'd0,        MODE_HUNDREDTHS, ssnd_pkg::PREFIX_DIGIT, 1'b1, 40'h7E7EFE7E7E},
      '{32'd12345,    MODE_PLAIN,      ssnd_pkg::PREFIX_DIGIT, 1'b1, 40'h483D6D4B67},
      '{32'd67890,    MODE_PLAIN,      ssnd_pkg::PREFIX_DIGIT, 1'b1, 40'h774C7F6F7E},
      '{32'd99999,    MODE_PLAIN,      ssnd_pkg::PREFIX_DIGIT, 1'b1, 40'h6F6F6F6F6F},
      '{32'd100000,   MODE_PLAIN,      ssnd_pkg::PREFIX_DIGIT, 1'b1, 40'h7E7E7E7E7E},
      '{32'd99999,    MODE_HUNDREDTHS, ssnd_pkg::PREFIX_H,     1'b1, 40'h6F6FEF6F6F},
      '{32'd100000,   MODE_HUNDREDTHS, ssnd_pkg::PREFIX_DIGIT, 1'b1, 40'h7E487E7E7E},
      '{32'hFFFFFFFF, MODE_PLAIN,      ssnd_pkg::PREFIX_DIGIT, 1'b0, 40'h0},
      '{32'hFFFFFFFF, MODE_HUNDREDTHS, ssnd_pkg::PREFIX_P,     1'b0, 40'h0},
      '{32'hFFFFFFFF, MODE_PLAIN,      ssnd_pkg::PREFIX_H,     1'b0, 40'h0},
      '{32'd12345,    MODE_HUNDREDTHS, PREFIX_BLANK,           1'b0, 40'h0},
      '{32'd100099,   MODE_HUNDREDTHS, ssnd_pkg::PREFIX_DIGIT, 1'b0, 40'h0},
      '{32'd9999999,  MODE_HUNDREDTHS, ssnd_pkg::PREFIX_DIGIT, 1'b0, 40'h0},
      '{32'd10000099, MODE_HUNDREDTHS, ssnd_pkg::PREFIX_H,     1'b0, 40'h0},
      '{32'd54321,    MODE_PLAIN,      ssnd_pkg::PREFIX_P,     1'b0, 40'h0},
      '{32'd1,        MODE_HUNDREDTHS, ssnd_pkg::PREFIX_DIGIT, 1'b0, 40'h0},
      '{32'h80000000, MODE_PLAIN,      PREFIX_BLANK,           1'b0, 40'h0},
      '{32'h55555555, MODE_HUNDREDTHS, ssnd_pkg::PREFIX_DIGIT, 1'b0, 40'h0},
      '{32'hAAAAAAAA, MODE_PLAIN,      ssnd_pkg::PREFIX_DIGIT, 1'b0, 40'h0}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].value, directed_rows[r].mode, directed_rows[r].prefix,
                directed_rows[r].typed, directed_rows[r].segs);
    end

    // Random items with idling on both sides.
    repeat (50) send_random_item();

    // A stretch without any idling.
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    repeat (20) send_random_item();

    // Long output hold-off while the sender keeps offering transfers.
    hold_request = 1'b1;
    repeat (20) send_random_item();

    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    repeat (20) send_random_item();

    // Final part runs without idling.
    sender_idle   = 1'b0;
    receiver_idle = 1'b0;
    repeat (20) send_random_item();

    @(negedge clk);
    valid_i <= 1'b0;
    while (digit_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (plain, hundredths, all prefixes, overflow and truncation).",
             items_sent);
    $display("Checked %0d digit transfers across idle bursts and a %0d-cycle hold-off.",
             digits_checked, LONG_HOLD_CYCLES);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
